[rtl/gdlc_pkg.sv]
package gdlc_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   localparam logic CSR_IDX_STANDARD = 1'b0;
   localparam logic CSR_IDX_DAYLIGHT = 1'b1;

   localparam logic [4:0] STANDARD_OFFSET_RESET = 5'd5;
   localparam logic [4:0] DAYLIGHT_OFFSET_RESET = 5'd4;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_MAR = 4'd3;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic       fix_valid;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [4:0] day;
      logic [3:0] month;
      logic [6:0] year;
   } req_item_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [4:0] day;
      logic [3:0] month;
      logic [6:0] year;
      logic [2:0] weekday;
      logic       common_year;
      logic [4:0] zone;
   } clock_state_type;

   typedef logic [127:0][2:0] year_term_tbl_type;
   typedef logic [127:0]      leap_tbl_type;

   // Year part of the weekday formula. Year 0 stores 6, which is the
   // formula's -1 taken modulo 7; the caller handles the case where the
   // whole sum is -1.
   function automatic year_term_tbl_type build_year_terms();
      year_term_tbl_type t;
      int                a;
      int                x;
      t[0] = 3'd6;
      for (a = 1; a < 128; a++) begin
         x    = (a - 1) / 4 - (3 * ((a - 1) / 100 + 1)) / 4;
         t[a] = 3'((((a - 1) % 7) + (x % 7)) % 7);
      end
      return t;
   endfunction

   function automatic leap_tbl_type build_leap_flags();
      leap_tbl_type t;
      int           a;
      for (a = 0; a < 128; a++) begin
         t[a] = ((a % 4 == 0) && (a % 100 != 0)) || (a % 400 == 0);
      end
      return t;
   endfunction

   localparam year_term_tbl_type YEAR_TERMS = build_year_terms();
   localparam leap_tbl_type      LEAP_FLAGS = build_leap_flags();

   function automatic logic [2:0] month_term(input logic leap, input logic [3:0] month);
      logic [2:0] c;
      logic [2:0] l;
      unique case (month)
         4'd1:    begin c = 3'd0; l = 3'd0; end
         4'd2:    begin c = 3'd3; l = 3'd3; end
         4'd3:    begin c = 3'd3; l = 3'd4; end
         4'd4:    begin c = 3'd6; l = 3'd0; end
         4'd5:    begin c = 3'd1; l = 3'd2; end
         4'd6:    begin c = 3'd4; l = 3'd5; end
         4'd7:    begin c = 3'd6; l = 3'd0; end
         4'd8:    begin c = 3'd2; l = 3'd3; end
         4'd9:    begin c = 3'd5; l = 3'd6; end
         4'd10:   begin c = 3'd0; l = 3'd1; end
         4'd11:   begin c = 3'd3; l = 3'd4; end
         4'd12:   begin c = 3'd5; l = 3'd6; end
         default: begin c = 3'd0; l = 3'd0; end
      endcase
      return leap ? l : c;
   endfunction

   // Length of the month before the given one; March is handled by the caller.
   function automatic logic [4:0] prev_month_len(input logic [3:0] month);
      logic [4:0] len;
      unique case (month)
         4'd1, 4'd2, 4'd4, 4'd6, 4'd8, 4'd9, 4'd11: len = 5'd31;
         4'd5, 4'd7, 4'd10, 4'd12:                  len = 5'd30;
         default:                                   len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

[rtl/gdlc_csr.sv]
module gdlc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [gdlc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gdlc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gdlc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output logic [4:0]                     standard_offset,
   output logic [4:0]                     daylight_offset
);
   import gdlc_pkg::*;

   logic [4:0] standard_ff, standard_in;
   logic [4:0] daylight_ff, daylight_in;
   logic       write_en;
   logic       reg_idx;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[2];

   always_comb begin
      standard_in = standard_ff;
      daylight_in = daylight_ff;
      csr_prdata  = '0;
      unique case (reg_idx)
         CSR_IDX_STANDARD: begin
            csr_prdata = {{(CSR_DATA_W-5){1'b0}}, standard_ff};
            if (write_en) begin
               standard_in = csr_pwdata[4:0];
            end
         end
         CSR_IDX_DAYLIGHT: begin
            csr_prdata = {{(CSR_DATA_W-5){1'b0}}, daylight_ff};
            if (write_en) begin
               daylight_in = csr_pwdata[4:0];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         standard_ff <= STANDARD_OFFSET_RESET;
         daylight_ff <= DAYLIGHT_OFFSET_RESET;
      end else begin
         standard_ff <= standard_in;
         daylight_ff <= daylight_in;
      end
   end

   assign standard_offset = standard_ff;
   assign daylight_offset = daylight_ff;

endmodule

[rtl/gdlc_step.sv]
module gdlc_step (
   input  gdlc_pkg::req_item_type    item,
   input  gdlc_pkg::clock_state_type cur,
   input  logic [4:0]                standard_offset,
   input  logic [4:0]                daylight_offset,
   output gdlc_pkg::clock_state_type nxt
);
   import gdlc_pkg::*;

   logic [5:0] load_sum;
   logic [6:0] fr_sec, fr_min;
   logic [5:0] fr_hour, fr_day;
   logic [4:0] fr_month;
   logic [6:0] fr_year;
   logic [4:0] t_hour, t_day;
   logic [5:0] t_min, t_sec;
   logic [3:0] t_month;
   logic [6:0] t_year;
   logic       leap;
   logic [2:0] mterm, yterm, dmod;
   logic [3:0] dfold;
   logic [4:0] wsum;
   logic [2:0] wday;
   logic       hole;
   logic [4:0] zone;

   assign load_sum = {1'b0, item.hour} + 6'd24 - {1'b0, cur.zone};

   always_comb begin
      // Free-running one-second advance with carries.
      fr_sec   = {1'b0, cur.second} + 7'd1;
      fr_min   = {1'b0, cur.minute};
      fr_hour  = {1'b0, cur.hour};
      fr_day   = {1'b0, cur.day};
      fr_month = {1'b0, cur.month};
      fr_year  = cur.year;
      if (fr_sec > 7'd59) begin
         fr_min = fr_min + 7'd1;
         fr_sec = '0;
      end
      if (fr_min > 7'd59) begin
         fr_hour = fr_hour + 6'd1;
         fr_min  = '0;
      end
      if (fr_hour > 6'd23) begin
         fr_day  = fr_day + 6'd1;
         fr_hour = '0;
      end
      if (fr_day > 6'd31) begin
         fr_month = fr_month + 5'd1;
         fr_day   = 6'd1;
      end
      if (fr_month > 5'd12) begin
         fr_year  = (fr_year >= 7'd99) ? 7'd0 : fr_year + 7'd1;
         fr_month = 5'd1;
      end

      // Load from a fix, advance, or hold when never set.
      t_hour  = cur.hour;
      t_min   = cur.minute;
      t_sec   = cur.second;
      t_day   = cur.day;
      t_month = cur.month;
      t_year  = cur.year;
      if (item.fix_valid) begin
         t_min   = item.minute;
         t_sec   = item.second;
         t_month = item.month;
         t_year  = item.year;
         if (item.hour < cur.zone) begin
            t_hour = load_sum[4:0];
            t_day  = item.day - 5'd1;
         end else begin
            t_hour = item.hour - cur.zone;
            t_day  = item.day;
         end
      end else if (cur.day != 5'd0) begin
         t_hour  = fr_hour[4:0];
         t_min   = fr_min[5:0];
         t_sec   = fr_sec[5:0];
         t_day   = fr_day[4:0];
         t_month = fr_month[3:0];
         t_year  = fr_year;
      end

      // Day 0 rolls back to the last day of the previous month.
      if (t_day == 5'd0 && t_month >= MONTH_JAN && t_month <= MONTH_DEC) begin
         if (t_month == MONTH_JAN) begin
            t_day   = 5'd31;
            t_month = MONTH_DEC;
            t_year  = (t_year == 7'd0) ? 7'd99 : t_year - 7'd1;
         end else begin
            if (t_month == MONTH_MAR) begin
               t_day = cur.common_year ? 5'd28 : 5'd29;
            end else begin
               t_day = prev_month_len(t_month);
            end
            t_month = t_month - 4'd1;
         end
      end

      // Weekday from the year, month and day terms, all modulo 7.
      leap  = LEAP_FLAGS[t_year];
      mterm = month_term(leap, t_month);
      yterm = YEAR_TERMS[t_year];
      dfold = {2'b00, t_day[4:3]} + {1'b0, t_day[2:0]};
      dmod  = (dfold >= 4'd7) ? 3'(dfold - 4'd7) : dfold[2:0];
      wsum  = {2'b00, yterm} + {2'b00, mterm} + {2'b00, dmod};
      priority if (wsum >= 5'd14) begin
         wday = 3'(wsum - 5'd14);
      end else if (wsum >= 5'd7) begin
         wday = 3'(wsum - 5'd7);
      end else begin
         wday = wsum[2:0];
      end
      hole = (t_year == 7'd0) && (mterm == 3'd0) && (dmod == 3'd0);
      if (hole) begin
         wday = cur.weekday;
      end

      // Zone choice by season and the daylight-saving switch Sundays.
      zone = cur.zone;
      if (cur.zone == 5'd0) begin
         if (t_month >= MONTH_MAR && t_month < MONTH_NOV) begin
            zone = daylight_offset;
         end
         if (t_month >= MONTH_NOV || t_month == MONTH_JAN || t_month == MONTH_FEB) begin
            zone = standard_offset;
         end
      end
      if (t_month == MONTH_MAR && t_day > 5'd7 && wday == 3'd0) begin
         zone = daylight_offset;
      end
      if (t_month == MONTH_NOV && wday == 3'd0) begin
         zone = standard_offset;
      end

      nxt.hour        = t_hour;
      nxt.minute      = t_min;
      nxt.second      = t_sec;
      nxt.day         = t_day;
      nxt.month       = t_month;
      nxt.year        = t_year;
      nxt.weekday     = wday;
      nxt.common_year = ~leap;
      nxt.zone        = zone;
   end

endmodule

[rtl/gps_disciplined_local_clock.sv]
// Local calendar clock kept in step by GPS. Each item is one second: with
// req_tuser high it carries a GPS fix and loads UTC minus the zone offset,
// with req_tuser low it advances the clock by one second once the clock has
// been set. Every item yields exactly one result item with the local time,
// date, weekday, leap flag and the offset for the next fix. An item passes
// an input register and then the clock state register, which is also the
// result register; one item is taken every cycle while the result register
// is empty or rsp_tready is high, as the clock state register is updated
// from its own previous value. Offsets are written through the csr_ port.
module gps_disciplined_local_clock (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [4:0] utc_hour, [10:5] utc_minute, [16:11] utc_second, [21:17] utc_day,
   // [25:22] utc_month, [32:26] utc_year, rest zero
   input  logic [gdlc_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] fix_valid
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [4:0] local_hour, [10:5] local_minute, [16:11] local_second,
   // [21:17] local_day, [25:22] local_month, [32:26] local_year,
   // [35:33] weekday, [36] common_year, [41:37] zone_hours, rest zero
   output logic [gdlc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [gdlc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gdlc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gdlc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import gdlc_pkg::*;

   logic            in_valid_ff, in_valid_in;
   req_item_type    in_item_ff, in_item_in;
   logic            out_valid_ff, out_valid_in;
   clock_state_type state_ff, state_in, step_nxt;
   logic [4:0]      standard_offset, daylight_offset;
   logic            advance;

   gdlc_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .standard_offset (standard_offset),
      .daylight_offset (daylight_offset)
   );

   gdlc_step u_step (
      .item            (in_item_ff),
      .cur             (state_ff),
      .standard_offset (standard_offset),
      .daylight_offset (daylight_offset),
      .nxt             (step_nxt)
   );

   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;

   always_comb begin
      in_item_in.fix_valid = req_tuser;
      in_item_in.hour      = req_tdata[4:0];
      in_item_in.minute    = req_tdata[10:5];
      in_item_in.second    = req_tdata[16:11];
      in_item_in.day       = req_tdata[21:17];
      in_item_in.month     = req_tdata[25:22];
      in_item_in.year      = req_tdata[32:26];

      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end

      out_valid_in = out_valid_ff & ~rsp_tready;
      state_in     = state_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         state_in     = step_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_item_ff <= in_item_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-42){1'b0}},
                        state_ff.zone, state_ff.common_year, state_ff.weekday,
                        state_ff.year, state_ff.month, state_ff.day,
                        state_ff.second, state_ff.minute, state_ff.hour};

endmodule

[rtl/gdlc_checker.sv]
module gdlc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [gdlc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled result item holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // No result item is shown right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // The weekday never takes the unused code 7.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[35:33] != 3'd7)
      else $error("weekday out of range");

   // A year that is not a multiple of four is always a common year.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[27:26] != 2'd0 |-> rsp_tdata[36])
      else $error("leap flag wrong for year");

endmodule

bind gps_disciplined_local_clock gdlc_checker u_gdlc_checker (.*);
